### hw/rtl/blecrc_pkg.sv
// Shared types, constants and CRC-24 helper functions for the BLE advertising CRC checker.
package blecrc_pkg;

    localparam logic [23:0] CRC_POLY        = 24'h00065B;
    localparam logic [23:0] CRC_START_RESET = 24'h555555;
    localparam logic [7:0]  MAX_PDU_LEN     = 8'd37;

    localparam logic [8:0]  POS_HEADER      = 9'd0;
    localparam logic [8:0]  POS_LENGTH      = 9'd1;
    localparam logic [8:0]  CRC_HEAD_BYTES  = 9'd2;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       frame_start;
    } blecrc_item_t;

    typedef struct packed {
        logic        crc_ok;
        logic        length_error;
        logic [7:0]  payload_length;
        logic [23:0] computed_crc;
    } blecrc_result_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        c = crc ^ {rev8(b), 16'h0000};
        for (int i = 0; i < 8; i++)
        begin
            if (c[23])
            begin
                c = {c[22:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[22:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [23:0] crc_as_sent(input logic [23:0] crc);
        return {rev8(crc[23:16]), rev8(crc[15:8]), rev8(crc[7:0])};
    endfunction

endpackage

### hw/rtl/blecrc_ifs.sv
// Valid/ready channel interfaces for received bytes and check results.
interface blecrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface blecrc_res_if;
    logic        valid;
    logic        ready;
    logic        crc_ok;
    logic        length_error;
    logic [7:0]  payload_length;
    logic [23:0] computed_crc;

    modport source (output valid, output crc_ok, output length_error,
                    output payload_length, output computed_crc, input ready);
    modport sink (input valid, input crc_ok, input length_error,
                  input payload_length, input computed_crc, output ready);
endinterface

### hw/rtl/blecrc_in_reg.sv
// Input register stage that captures one received byte beat.
module blecrc_in_reg
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [7:0]               in_data_byte,
    input  logic                     in_frame_start,
    output logic                     in_ready,
    input  logic                     take,
    output blecrc_pkg::blecrc_item_t item
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;

    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= in_data_byte;
            start_reg <= in_frame_start;
        end
    end

    assign item.valid       = valid_reg;
    assign item.data_byte   = byte_reg;
    assign item.frame_start = start_reg;

endmodule

### hw/rtl/blecrc_engine.sv
// Packet framing state and byte-wide CRC-24 update for the registered byte.
module blecrc_engine
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  blecrc_pkg::blecrc_item_t   item,
    input  logic [23:0]                crc_start,
    input  logic                       out_free,
    output logic                       take,
    output logic                       res_load,
    output blecrc_pkg::blecrc_result_t res
);

    logic [23:0] crc_reg, crc_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] rcv_reg, rcv_next;
    logic        inp_reg, inp_next;

    logic [23:0] crc_cur;
    logic [8:0]  pos_cur;
    logic [7:0]  len_cur;
    logic [15:0] rcv_cur;
    logic        inp_cur;
    logic [8:0]  crc_first;
    logic [23:0] rcv_full;
    logic [23:0] sent;
    logic        gen;

    always_comb
    begin
        crc_cur   = item.frame_start ? crc_start : crc_reg;
        pos_cur   = item.frame_start ? '0 : pos_reg;
        len_cur   = item.frame_start ? '0 : len_reg;
        rcv_cur   = item.frame_start ? '0 : rcv_reg;
        inp_cur   = item.frame_start || inp_reg;
        crc_first = blecrc_pkg::CRC_HEAD_BYTES + {1'b0, len_cur};
        rcv_full  = {rcv_cur, item.data_byte};
        sent      = blecrc_pkg::crc_as_sent(crc_cur);

        crc_next  = crc_cur;
        pos_next  = pos_cur;
        len_next  = len_cur;
        rcv_next  = rcv_cur;
        inp_next  = inp_cur;
        gen       = 1'b0;
        res       = '0;

        if (inp_cur)
        begin
            priority if (pos_cur == blecrc_pkg::POS_HEADER)
            begin
                crc_next = blecrc_pkg::crc_feed(crc_cur, item.data_byte);
                pos_next = blecrc_pkg::POS_LENGTH;
            end
            else if (pos_cur == blecrc_pkg::POS_LENGTH)
            begin
                len_next = item.data_byte;
                crc_next = blecrc_pkg::crc_feed(crc_cur, item.data_byte);
                pos_next = blecrc_pkg::CRC_HEAD_BYTES;
                if (item.data_byte > blecrc_pkg::MAX_PDU_LEN)
                begin
                    inp_next           = 1'b0;
                    gen                = 1'b1;
                    res.length_error   = 1'b1;
                    res.payload_length = item.data_byte;
                end
            end
            else if (pos_cur < crc_first)
            begin
                crc_next = blecrc_pkg::crc_feed(crc_cur, item.data_byte);
                pos_next = pos_cur + 9'd1;
            end
            else if (pos_cur < crc_first + 9'd2)
            begin
                rcv_next = rcv_full[15:0];
                pos_next = pos_cur + 9'd1;
            end
            else
            begin
                rcv_next           = rcv_full[15:0];
                inp_next           = 1'b0;
                gen                = 1'b1;
                res.crc_ok         = (sent == rcv_full);
                res.payload_length = len_cur;
                res.computed_crc   = sent;
            end
        end
    end

    assign take     = item.valid && (!gen || out_free);
    assign res_load = take && gen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= blecrc_pkg::CRC_START_RESET;
            pos_reg <= '0;
            len_reg <= '0;
            rcv_reg <= '0;
            inp_reg <= 1'b0;
        end
        else if (take)
        begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            rcv_reg <= rcv_next;
            inp_reg <= inp_next;
        end
    end

    a_result_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> !inp_reg)
        else $error("Packet still open after its result beat.");

    a_position_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inp_reg |-> (pos_reg != '0 && pos_reg <= {1'b0, len_reg} + 9'd4))
        else $error("Byte position ran past the CRC bytes.");

    a_length_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.length_error) |-> (!res.crc_ok && res.computed_crc == '0))
        else $error("Length error result carries a CRC verdict.");

endmodule

### hw/rtl/blecrc_out_reg.sv
// Output register that holds one result beat until it is taken.
module blecrc_out_reg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  blecrc_pkg::blecrc_result_t res_in,
    output logic                       out_free,
    output logic                       out_valid,
    input  logic                       out_ready,
    output blecrc_pkg::blecrc_result_t res_out
);

    logic                       valid_reg;
    blecrc_pkg::blecrc_result_t data_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

### hw/rtl/ble_adv_crc24_checker_core.sv
// Top level of the BLE advertising packet CRC-24 checker.
// A packet's last byte goes through the input register; its result beat then loads into the output register.
// One byte is accepted every cycle; the input stalls only while a result beat waits
// and the byte in the input register would produce another one.
// Reset clears all framing state, restores the start value 0x555555 and empties
// both registers; there is no clearing pass.
module ble_adv_crc24_checker_core
(
    input  logic        clk,
    input  logic        rst_n,
    blecrc_rx_if.sink   rx,
    blecrc_res_if.source res,
    input  logic        cfg_write_en,
    input  logic [23:0] cfg_write_data
);

    logic [23:0]                crc_start_reg;
    blecrc_pkg::blecrc_item_t   item;
    blecrc_pkg::blecrc_result_t eng_res;
    blecrc_pkg::blecrc_result_t out_res;
    logic                       take;
    logic                       res_load;
    logic                       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_start_reg <= blecrc_pkg::CRC_START_RESET;
        end
        else if (cfg_write_en)
        begin
            crc_start_reg <= cfg_write_data;
        end
    end

    blecrc_in_reg u_in_reg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (rx.valid),
        .in_data_byte   (rx.data_byte),
        .in_frame_start (rx.frame_start),
        .in_ready       (rx.ready),
        .take           (take),
        .item           (item)
    );

    blecrc_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .crc_start (crc_start_reg),
        .out_free  (out_free),
        .take      (take),
        .res_load  (res_load),
        .res       (eng_res)
    );

    blecrc_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_in    (eng_res),
        .out_free  (out_free),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .res_out   (out_res)
    );

    assign res.crc_ok         = out_res.crc_ok;
    assign res.length_error   = out_res.length_error;
    assign res.payload_length = out_res.payload_length;
    assign res.computed_crc   = out_res.computed_crc;

endmodule

### test/adv_crc_watch.sv
// Predicts and checks the result beats of the BLE advertising CRC-24 checker.
`timescale 1ns / 100ps

module adv_crc_watch
(
    input  logic        clk,
    input  logic        rst_n,
    blecrc_rx_if        rx,
    blecrc_res_if       res,
    input  logic        cfg_write_en,
    input  logic [23:0] cfg_write_data,
    output int          fail_count,
    output int          awaiting
);

    logic [23:0]                crc_seed;
    logic [23:0]                crc_acc;
    logic [8:0]                 byte_pos;
    logic [7:0]                 pdu_len;
    logic [23:0]                crc_heard;
    logic                       inside_pdu;
    int                         err_total;
    blecrc_pkg::blecrc_result_t pending_results[$];

    function automatic logic [7:0] flip_bits8(input logic [7:0] b);
        return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    endfunction

    function automatic logic [23:0] crc24_next(input logic [23:0] c_in, input logic [7:0] b);
        logic [23:0] c;
        int          k;
        c = c_in ^ {flip_bits8(b), 16'h0000};
        for (k = 0; k < 8; k++)
        begin
            if (c[23])
            begin
                c = {c[22:0], 1'b0} ^ blecrc_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[22:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [23:0] crc24_on_air(input logic [23:0] c);
        return {flip_bits8(c[23:16]), flip_bits8(c[15:8]), flip_bits8(c[7:0])};
    endfunction

    task automatic step_packet_byte(input logic [7:0] b, input logic fs);
        blecrc_pkg::blecrc_result_t r;
        logic [8:0]                 crc_first;
        logic [23:0]                on_air;
        if (fs)
        begin
            crc_acc    = crc_seed;
            byte_pos   = blecrc_pkg::POS_HEADER;
            pdu_len    = 8'd0;
            crc_heard  = 24'd0;
            inside_pdu = 1'b1;
        end
        if (inside_pdu)
        begin
            if (byte_pos == blecrc_pkg::POS_HEADER)
            begin
                crc_acc  = crc24_next(crc_acc, b);
                byte_pos = blecrc_pkg::POS_LENGTH;
            end
            else if (byte_pos == blecrc_pkg::POS_LENGTH)
            begin
                pdu_len  = b;
                crc_acc  = crc24_next(crc_acc, b);
                byte_pos = blecrc_pkg::CRC_HEAD_BYTES;
                if (b > blecrc_pkg::MAX_PDU_LEN)
                begin
                    inside_pdu       = 1'b0;
                    r.crc_ok         = 1'b0;
                    r.length_error   = 1'b1;
                    r.payload_length = b;
                    r.computed_crc   = 24'd0;
                    pending_results.push_back(r);
                end
            end
            else
            begin
                crc_first = blecrc_pkg::CRC_HEAD_BYTES + {1'b0, pdu_len};
                if (byte_pos < crc_first)
                begin
                    crc_acc  = crc24_next(crc_acc, b);
                    byte_pos = byte_pos + 9'd1;
                end
                else
                begin
                    crc_heard = {crc_heard[15:0], b};
                    if (byte_pos < crc_first + 9'd2)
                    begin
                        byte_pos = byte_pos + 9'd1;
                    end
                    else
                    begin
                        inside_pdu       = 1'b0;
                        on_air           = crc24_on_air(crc_acc);
                        r.crc_ok         = (on_air == crc_heard);
                        r.length_error   = 1'b0;
                        r.payload_length = pdu_len;
                        r.computed_crc   = on_air;
                        pending_results.push_back(r);
                    end
                end
            end
        end
    endtask

    task automatic check_beat;
        blecrc_pkg::blecrc_result_t want;
        bit                         bad;
        if (pending_results.size() == 0)
        begin
            $display("%0t ERROR result beat: expected none, actual ok %0b len_err %0b",
                     $time, res.crc_ok, res.length_error);
            $display("%0t ERROR result beat: actual len %0d crc %06h",
                     $time, res.payload_length, res.computed_crc);
            err_total++;
        end
        else
        begin
            want = pending_results.pop_front();
            bad  = 1'b0;
            if (res.crc_ok !== want.crc_ok)
            begin
                $display("%0t ERROR crc_ok: expected %0b, actual %0b",
                         $time, want.crc_ok, res.crc_ok);
                bad = 1'b1;
            end
            if (res.length_error !== want.length_error)
            begin
                $display("%0t ERROR length_error: expected %0b, actual %0b",
                         $time, want.length_error, res.length_error);
                bad = 1'b1;
            end
            if (res.payload_length !== want.payload_length)
            begin
                $display("%0t ERROR payload_length: expected %0d, actual %0d",
                         $time, want.payload_length, res.payload_length);
                bad = 1'b1;
            end
            if (res.computed_crc !== want.computed_crc)
            begin
                $display("%0t ERROR computed_crc: expected %06h, actual %06h",
                         $time, want.computed_crc, res.computed_crc);
                bad = 1'b1;
            end
            if (bad)
            begin
                err_total++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_seed   = blecrc_pkg::CRC_START_RESET;
            crc_acc    = blecrc_pkg::CRC_START_RESET;
            byte_pos   = blecrc_pkg::POS_HEADER;
            pdu_len    = 8'd0;
            crc_heard  = 24'd0;
            inside_pdu = 1'b0;
            err_total  = 0;
            pending_results.delete();
            fail_count <= 0;
            awaiting   <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                crc_seed = cfg_write_data;
            end
            if (res.valid && res.ready)
            begin
                check_beat();
            end
            if (rx.valid && rx.ready)
            begin
                step_packet_byte(rx.data_byte, rx.frame_start);
            end
            fail_count <= err_total;
            awaiting   <= pending_results.size();
        end
    end

endmodule

### test/tb_top.sv
// Testbench top: clock, reset, packet stimulus, result stalls and the final verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_BYTES  = 220;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [23:0] cfg_write_data;
    int          fail_count;
    int          awaiting;
    int          bytes_fed;
    int          burst_left;
    int          hold_asked;
    int          quiet_cycles = 0;
    logic [23:0] seed_now;

    blecrc_rx_if  rx_ch ();
    blecrc_res_if res_ch ();

    ble_adv_crc24_checker_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_ch),
        .res            (res_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    adv_crc_watch watch
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_ch),
        .res            (res_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fail_count     (fail_count),
        .awaiting       (awaiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int holds_done;
        int mode;
        int mode_left;
        holds_done = 0;
        mode       = 0;
        mode_left  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != holds_done)
            begin
                holds_done = hold_asked;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 9) < 6);
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(60, 150);
            end
            else
            begin
                gap        = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 20);
            end
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid       <= 1'b1;
        rx_ch.data_byte   <= b;
        rx_ch.frame_start <= fs;
        do
        begin
            @(posedge clk);
        end
        while (rx_ch.ready !== 1'b1);
    endtask

    // Sends header and length; if len <= MAX_PDU_LEN, payload and CRC bytes below index cut (-1 for all).
    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] len, input int cut,
                               input int fill, input bit corrupt);
        logic [23:0] crc;
        logic [23:0] sent;
        logic [7:0]  b;
        int          i;
        send_byte(hdr, 1'b1);
        send_byte(len, 1'b0);
        bytes_fed += 2;
        crc = blecrc_pkg::crc_feed(blecrc_pkg::crc_feed(seed_now, hdr), len);
        if (len <= blecrc_pkg::MAX_PDU_LEN)
        begin
            for (i = 0; i < len + 3 && i != cut; i++)
            begin
                if (i < len)
                begin
                    b   = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
                    crc = blecrc_pkg::crc_feed(crc, b);
                end
                else
                begin
                    if (i == len)
                    begin
                        sent = blecrc_pkg::crc_as_sent(crc);
                        if (corrupt)
                        begin
                            sent = sent ^ (24'd1 << $urandom_range(0, 23));
                        end
                    end
                    b = (i == len) ? sent[23:16] : (i == len + 1) ? sent[15:8] : sent[7:0];
                end
                send_byte(b, 1'b0);
                bytes_fed++;
            end
        end
    endtask

    task automatic wait_drained;
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_start(input logic [23:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        seed_now = v;
    endtask

    task automatic random_traffic(input int upto);
        int pick;
        int len;
        int n;
        int j;
        while (bytes_fed < upto)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                bytes_fed++;
            end
            else if (pick < 14)
            begin
                send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(38, 255)), -1, -1,
                            1'b0);
                n = $urandom_range(0, 3);
                for (j = 0; j < n; j++)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    bytes_fed++;
                end
            end
            else if (pick < 24)
            begin
                len = $urandom_range(0, 37);
                send_packet(8'($urandom_range(0, 255)), 8'(len), int'($urandom_range(0, len + 2)),
                            -1, 1'b0);
            end
            else
            begin
                n   = $urandom_range(0, 9);
                len = (n == 0) ? 0 : (n == 1) ? 37 : $urandom_range(0, 37);
                send_packet(8'($urandom_range(0, 255)), 8'(len), -1, -1,
                            $urandom_range(0, 6) == 0);
            end
        end
    endtask

    initial
    begin
        int          ph;
        logic [23:0] seeds [5];
        rst_n             = 1'b0;
        cfg_write_en      = 1'b0;
        cfg_write_data    = 24'd0;
        rx_ch.valid       = 1'b0;
        rx_ch.data_byte   = 8'd0;
        rx_ch.frame_start = 1'b0;
        hold_asked        = 0;
        burst_left        = 0;
        bytes_fed         = 0;
        seed_now          = blecrc_pkg::CRC_START_RESET;
        seeds[0] = 24'h000000;
        seeds[1] = 24'hFFFFFF;
        seeds[2] = 24'($urandom_range(0, 24'hFFFFFF));
        seeds[3] = 24'($urandom_range(0, 24'hFFFFFF));
        seeds[4] = blecrc_pkg::CRC_START_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'hFF, 1'b0);
        send_packet(8'h00, 8'd0, -1, -1, 1'b0);
        send_packet(8'hFF, 8'd38, -1, -1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_packet(8'h5A, 8'd255, -1, -1, 1'b0);
        send_packet(8'hA5, 8'd3, 2, -1, 1'b0);
        send_packet(8'hFF, 8'd1, -1, 8'hFF, 1'b1);
        send_packet(8'h00, 8'd2, -1, 8'h00, 1'b0);

        for (ph = 0; ph < 5; ph++)
        begin
            wait_drained();
            write_start(seeds[ph]);
            if (ph == 2)
            begin
                hold_asked <= hold_asked + 1;
            end
            random_traffic(bytes_fed + PHASE_BYTES);
        end
        wait_drained();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/blecrc_pkg.sv
hw/rtl/blecrc_ifs.sv
hw/rtl/blecrc_in_reg.sv
hw/rtl/blecrc_engine.sv
hw/rtl/blecrc_out_reg.sv
hw/rtl/ble_adv_crc24_checker_core.sv
test/adv_crc_watch.sv
test/tb_top.sv
